/* sv/rvdec_pkg.sv */
// Package for the RV32IM instruction decoder: opcode and funct7 codes,
// format classes, operation numbers and the per-funct3 operation tables.
// No dependencies.
package rvdec_pkg;

	localparam logic [6:0] OPC_REG    = 7'b0110011;
	localparam logic [6:0] OPC_IMM    = 7'b0010011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;

	localparam logic [6:0] F7_BASE   = 7'b0000000;
	localparam logic [6:0] F7_MULDIV = 7'b0000001;
	localparam logic [6:0] F7_ALT    = 7'b0100000;

	localparam logic [2:0] F3_SLL = 3'd1;
	localparam logic [2:0] F3_SRL = 3'd5;

	localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;

	typedef enum logic [2:0] {
		FMT_R   = 3'd0,
		FMT_IC  = 3'd1,
		FMT_IL  = 3'd2,
		FMT_S   = 3'd3,
		FMT_B   = 3'd4,
		FMT_U   = 3'd5,
		FMT_J   = 3'd6,
		FMT_UNK = 3'd7
	} fmt_t;

	typedef enum logic [5:0] {
		OP_UNKNOWN = 6'd0,
		OP_MUL     = 6'd1,
		OP_MULH    = 6'd2,
		OP_MULHSU  = 6'd3,
		OP_MULHU   = 6'd4,
		OP_DIV     = 6'd5,
		OP_DIVU    = 6'd6,
		OP_REM     = 6'd7,
		OP_REMU    = 6'd8,
		OP_ADD     = 6'd9,
		OP_SLL     = 6'd10,
		OP_SLT     = 6'd11,
		OP_SLTU    = 6'd12,
		OP_XOR     = 6'd13,
		OP_SRL     = 6'd14,
		OP_OR      = 6'd15,
		OP_AND     = 6'd16,
		OP_SUB     = 6'd17,
		OP_SRA     = 6'd18,
		OP_ADDI    = 6'd19,
		OP_ORI     = 6'd20,
		OP_ANDI    = 6'd21,
		OP_SLLI    = 6'd22,
		OP_SRAI    = 6'd23,
		OP_SRLI    = 6'd24,
		OP_SLTI    = 6'd25,
		OP_SLTIU   = 6'd26,
		OP_XORI    = 6'd27,
		OP_LB      = 6'd28,
		OP_LH      = 6'd29,
		OP_LW      = 6'd30,
		OP_LBU     = 6'd31,
		OP_LHU     = 6'd32,
		OP_JALR    = 6'd33,
		OP_SB      = 6'd34,
		OP_SH      = 6'd35,
		OP_SW      = 6'd36,
		OP_BEQ     = 6'd37,
		OP_BNE     = 6'd38,
		OP_BLT     = 6'd39,
		OP_BGE     = 6'd40,
		OP_BLTU    = 6'd41,
		OP_BGEU    = 6'd42,
		OP_LUI     = 6'd43,
		OP_AUIPC   = 6'd44,
		OP_JAL     = 6'd45
	} op_t;

	function automatic op_t op_muldiv(input logic [2:0] f3);
		op_t r;
		unique case (f3)
			3'd0: r = OP_MUL;
			3'd1: r = OP_MULH;
			3'd2: r = OP_MULHSU;
			3'd3: r = OP_MULHU;
			3'd4: r = OP_DIV;
			3'd5: r = OP_DIVU;
			3'd6: r = OP_REM;
			default: r = OP_REMU;
		endcase
		return r;
	endfunction

	function automatic op_t op_base(input logic [2:0] f3);
		op_t r;
		unique case (f3)
			3'd0: r = OP_ADD;
			3'd1: r = OP_SLL;
			3'd2: r = OP_SLT;
			3'd3: r = OP_SLTU;
			3'd4: r = OP_XOR;
			3'd5: r = OP_SRL;
			3'd6: r = OP_OR;
			default: r = OP_AND;
		endcase
		return r;
	endfunction

	function automatic op_t op_alt(input logic [2:0] f3);
		op_t r;
		unique case (f3)
			3'd0: r = OP_SUB;
			3'd5: r = OP_SRA;
			default: r = OP_UNKNOWN;
		endcase
		return r;
	endfunction

	function automatic op_t op_imm(input logic [2:0] f3);
		op_t r;
		unique case (f3)
			3'd0: r = OP_ADDI;
			3'd1: r = OP_SLLI;
			3'd2: r = OP_SLTI;
			3'd3: r = OP_SLTIU;
			3'd4: r = OP_XORI;
			3'd5: r = OP_SRLI;
			3'd6: r = OP_ORI;
			default: r = OP_ANDI;
		endcase
		return r;
	endfunction

	function automatic op_t op_load(input logic [2:0] f3);
		op_t r;
		unique case (f3)
			3'd0: r = OP_LB;
			3'd1: r = OP_LH;
			3'd2: r = OP_LW;
			3'd4: r = OP_LBU;
			3'd5: r = OP_LHU;
			default: r = OP_UNKNOWN;
		endcase
		return r;
	endfunction

	function automatic op_t op_store(input logic [2:0] f3);
		op_t r;
		unique case (f3)
			3'd0: r = OP_SB;
			3'd1: r = OP_SH;
			3'd2: r = OP_SW;
			default: r = OP_UNKNOWN;
		endcase
		return r;
	endfunction

	function automatic op_t op_branch(input logic [2:0] f3);
		op_t r;
		unique case (f3)
			3'd0: r = OP_BEQ;
			3'd1: r = OP_BNE;
			3'd4: r = OP_BLT;
			3'd5: r = OP_BGE;
			3'd6: r = OP_BLTU;
			3'd7: r = OP_BGEU;
			default: r = OP_UNKNOWN;
		endcase
		return r;
	endfunction

endpackage

/* sv/rv32im_instruction_decoder.sv */
// RV32IM instruction decoder: input register, decode logic, result register.
// Depends on rvdec_pkg.
//
// One instruction word is taken on each clock edge where start is high
// (busy is always low); it passes through the input and result registers,
// and its decoded fields then appear on the result ports with done high
// for one cycle. The decoder is fully pipelined: a new request may follow
// in every cycle, and the results come out in request order. The receiver
// cannot stall the output; every result must be taken in the cycle it is
// shown. Unknown encodings give format 7, operation 0 and a zero immediate;
// register-register instructions also give a zero immediate.
module rv32im_instruction_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [31:0]        instr_word,
	output logic               done,
	output logic [6:0]         major_opcode,
	output logic [4:0]         dest_reg,
	output logic [2:0]         func3_field,
	output logic [4:0]         src1_reg,
	output logic [4:0]         src2_reg,
	output logic [6:0]         func7_field,
	output logic [2:0]         format_class,
	output logic [5:0]         operation,
	output logic signed [31:0] immediate
);

	logic                 valid_s1;
	logic [31:0]          instr_s1;
	logic                 valid_s2;
	logic [31:0]          instr_s2;
	rvdec_pkg::fmt_t      fmt_s2;
	rvdec_pkg::op_t       op_s2;
	logic [31:0]          imm_s2;

	logic [6:0]           opc;
	logic [2:0]           f3;
	logic [6:0]           f7;
	rvdec_pkg::fmt_t      fmt_raw;
	rvdec_pkg::op_t       op_raw;
	logic [31:0]          imm_raw;
	rvdec_pkg::fmt_t      fmt_d;
	logic [31:0]          imm_d;
	logic [31:0]          imm_i;
	logic [31:0]          imm_sv;
	logic [31:0]          imm_b;
	logic [31:0]          imm_j;
	logic [31:0]          imm_u;
	logic [31:0]          shamt;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			instr_s1 <= instr_word;
		end
	end

	assign opc = instr_s1[6:0];
	assign f3  = instr_s1[14:12];
	assign f7  = instr_s1[31:25];

	assign imm_i  = {{20{instr_s1[31]}}, instr_s1[31:20]};
	assign imm_sv = {{20{instr_s1[31]}}, instr_s1[31:25], instr_s1[11:7]};
	assign imm_b  = {{20{instr_s1[31]}}, instr_s1[7], instr_s1[30:25],
			instr_s1[11:8], 1'b0};
	assign imm_j  = {{12{instr_s1[31]}}, instr_s1[19:12], instr_s1[20],
			instr_s1[30:21], 1'b0};
	assign imm_u  = instr_s1 & rvdec_pkg::UPPER_MASK;
	assign shamt  = {27'd0, instr_s1[24:20]};

	always_comb begin
		fmt_raw = rvdec_pkg::FMT_UNK;
		op_raw  = rvdec_pkg::OP_UNKNOWN;
		imm_raw = 32'd0;
		unique case (opc)
			rvdec_pkg::OPC_REG: begin
				fmt_raw = rvdec_pkg::FMT_R;
				if (f7 == rvdec_pkg::F7_MULDIV) begin
					op_raw = rvdec_pkg::op_muldiv(f3);
				end else if (f7 == rvdec_pkg::F7_BASE) begin
					op_raw = rvdec_pkg::op_base(f3);
				end else if (f7 == rvdec_pkg::F7_ALT) begin
					op_raw = rvdec_pkg::op_alt(f3);
				end
			end
			rvdec_pkg::OPC_IMM: begin
				fmt_raw = rvdec_pkg::FMT_IC;
				op_raw  = rvdec_pkg::op_imm(f3);
				imm_raw = imm_i;
				if (f3 == rvdec_pkg::F3_SRL && f7 == rvdec_pkg::F7_ALT) begin
					op_raw = rvdec_pkg::OP_SRAI;
				end
				if (f3 == rvdec_pkg::F3_SLL || f3 == rvdec_pkg::F3_SRL) begin
					imm_raw = shamt;
				end
			end
			rvdec_pkg::OPC_LOAD: begin
				fmt_raw = rvdec_pkg::FMT_IL;
				op_raw  = rvdec_pkg::op_load(f3);
				imm_raw = imm_i;
			end
			rvdec_pkg::OPC_JALR: begin
				fmt_raw = rvdec_pkg::FMT_IL;
				op_raw  = rvdec_pkg::OP_JALR;
				imm_raw = imm_i;
			end
			rvdec_pkg::OPC_STORE: begin
				fmt_raw = rvdec_pkg::FMT_S;
				op_raw  = rvdec_pkg::op_store(f3);
				imm_raw = imm_sv;
			end
			rvdec_pkg::OPC_BRANCH: begin
				fmt_raw = rvdec_pkg::FMT_B;
				op_raw  = rvdec_pkg::op_branch(f3);
				imm_raw = imm_b;
			end
			rvdec_pkg::OPC_LUI: begin
				fmt_raw = rvdec_pkg::FMT_U;
				op_raw  = rvdec_pkg::OP_LUI;
				imm_raw = imm_u;
			end
			rvdec_pkg::OPC_AUIPC: begin
				fmt_raw = rvdec_pkg::FMT_U;
				op_raw  = rvdec_pkg::OP_AUIPC;
				imm_raw = imm_u;
			end
			rvdec_pkg::OPC_JAL: begin
				fmt_raw = rvdec_pkg::FMT_J;
				op_raw  = rvdec_pkg::OP_JAL;
				imm_raw = imm_j;
			end
			default: begin
				fmt_raw = rvdec_pkg::FMT_UNK;
			end
		endcase
	end

	// drop the immediate for unknown and register-register encodings; unknown ones also get the unknown format
	always_comb begin
		fmt_d = fmt_raw;
		imm_d = imm_raw;
		if (op_raw == rvdec_pkg::OP_UNKNOWN) begin
			fmt_d = rvdec_pkg::FMT_UNK;
			imm_d = 32'd0;
		end
		if (fmt_d == rvdec_pkg::FMT_R) begin
			imm_d = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			instr_s2 <= instr_s1;
			fmt_s2   <= fmt_d;
			op_s2    <= op_raw;
			imm_s2   <= imm_d;
		end
	end

	assign done         = valid_s2;
	assign major_opcode = instr_s2[6:0];
	assign dest_reg     = instr_s2[11:7];
	assign func3_field  = instr_s2[14:12];
	assign src1_reg     = instr_s2[19:15];
	assign src2_reg     = instr_s2[24:20];
	assign func7_field  = instr_s2[31:25];
	assign format_class = fmt_s2;
	assign operation    = op_s2;
	assign immediate    = $signed(imm_s2);

endmodule

/* sim/tb_rv32im_instruction_decoder.sv */
`timescale 1ns / 100ps
// Testbench for rv32im_instruction_decoder: directed and random instruction words,
// predicted decode compared field by field against each done strobe.
// Depends on rvdec_pkg and the decoder RTL.
module tb_rv32im_instruction_decoder;

	typedef struct packed {
		logic [6:0]  opc;
		logic [4:0]  rd;
		logic [2:0]  f3;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [6:0]  f7;
		rvdec_pkg::fmt_t fmt;
		rvdec_pkg::op_t  op;
		logic [31:0] imm;
	} decoded_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [31:0]        instr_word = '0;
	logic               busy;
	logic               done;
	logic [6:0]         major_opcode;
	logic [4:0]         dest_reg;
	logic [2:0]         func3_field;
	logic [4:0]         src1_reg;
	logic [4:0]         src2_reg;
	logic [6:0]         func7_field;
	logic [2:0]         format_class;
	logic [5:0]         operation;
	logic signed [31:0] immediate;

	decoded_t expected_decodes[$];
	decoded_t want;
	int       mismatches = 0;
	int       requests_sent = 0;
	int       results_checked = 0;
	int       op_hits[0:63];
	bit       idle_enabled = 1'b1;

	rv32im_instruction_decoder dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.instr_word(instr_word), .done(done),
		.major_opcode(major_opcode), .dest_reg(dest_reg), .func3_field(func3_field),
		.src1_reg(src1_reg), .src2_reg(src2_reg), .func7_field(func7_field),
		.format_class(format_class), .operation(operation), .immediate(immediate)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("** rv32im_instruction_decoder: FAILED **");
		$finish;
	end

	function automatic decoded_t predict_decode(input logic [31:0] w);
		decoded_t d;
		logic [31:0] imm_i;
		imm_i = {{20{w[31]}}, w[31:20]};
		d.opc = w[6:0];
		d.rd = w[11:7];
		d.f3 = w[14:12];
		d.rs1 = w[19:15];
		d.rs2 = w[24:20];
		d.f7 = w[31:25];
		d.fmt = rvdec_pkg::FMT_UNK;
		d.op = rvdec_pkg::OP_UNKNOWN;
		d.imm = '0;
		case (w[6:0])
			rvdec_pkg::OPC_REG: begin
				d.fmt = rvdec_pkg::FMT_R;
				if (w[31:25] == rvdec_pkg::F7_MULDIV)
					d.op = rvdec_pkg::op_t'(rvdec_pkg::OP_MUL + w[14:12]);
				else if (w[31:25] == rvdec_pkg::F7_BASE)
					d.op = rvdec_pkg::op_t'(rvdec_pkg::OP_ADD + w[14:12]);
				else if (w[31:25] == rvdec_pkg::F7_ALT) begin
					if (w[14:12] == 3'd0)
						d.op = rvdec_pkg::OP_SUB;
					else if (w[14:12] == rvdec_pkg::F3_SRL)
						d.op = rvdec_pkg::OP_SRA;
				end
			end
			rvdec_pkg::OPC_IMM: begin
				d.fmt = rvdec_pkg::FMT_IC;
				d.imm = imm_i;
				case (w[14:12])
					3'd0: d.op = rvdec_pkg::OP_ADDI;
					3'd2: d.op = rvdec_pkg::OP_SLTI;
					3'd3: d.op = rvdec_pkg::OP_SLTIU;
					3'd4: d.op = rvdec_pkg::OP_XORI;
					3'd6: d.op = rvdec_pkg::OP_ORI;
					3'd7: d.op = rvdec_pkg::OP_ANDI;
					rvdec_pkg::F3_SLL: d.op = rvdec_pkg::OP_SLLI;
					default: d.op = (w[31:25] == rvdec_pkg::F7_ALT) ?
						rvdec_pkg::OP_SRAI : rvdec_pkg::OP_SRLI;
				endcase
				if (w[14:12] == rvdec_pkg::F3_SLL || w[14:12] == rvdec_pkg::F3_SRL)
					d.imm = {27'd0, w[24:20]};
			end
			rvdec_pkg::OPC_LOAD: begin
				d.fmt = rvdec_pkg::FMT_IL;
				d.imm = imm_i;
				case (w[14:12])
					3'd0: d.op = rvdec_pkg::OP_LB;
					3'd1: d.op = rvdec_pkg::OP_LH;
					3'd2: d.op = rvdec_pkg::OP_LW;
					3'd4: d.op = rvdec_pkg::OP_LBU;
					3'd5: d.op = rvdec_pkg::OP_LHU;
					default: d.op = rvdec_pkg::OP_UNKNOWN;
				endcase
			end
			rvdec_pkg::OPC_JALR: begin
				d.fmt = rvdec_pkg::FMT_IL;
				d.op = rvdec_pkg::OP_JALR;
				d.imm = imm_i;
			end
			rvdec_pkg::OPC_STORE: begin
				d.fmt = rvdec_pkg::FMT_S;
				d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
				case (w[14:12])
					3'd0: d.op = rvdec_pkg::OP_SB;
					3'd1: d.op = rvdec_pkg::OP_SH;
					3'd2: d.op = rvdec_pkg::OP_SW;
					default: d.op = rvdec_pkg::OP_UNKNOWN;
				endcase
			end
			rvdec_pkg::OPC_BRANCH: begin
				d.fmt = rvdec_pkg::FMT_B;
				d.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
				case (w[14:12])
					3'd0: d.op = rvdec_pkg::OP_BEQ;
					3'd1: d.op = rvdec_pkg::OP_BNE;
					3'd4: d.op = rvdec_pkg::OP_BLT;
					3'd5: d.op = rvdec_pkg::OP_BGE;
					3'd6: d.op = rvdec_pkg::OP_BLTU;
					3'd7: d.op = rvdec_pkg::OP_BGEU;
					default: d.op = rvdec_pkg::OP_UNKNOWN;
				endcase
			end
			rvdec_pkg::OPC_LUI: begin
				d.fmt = rvdec_pkg::FMT_U;
				d.op = rvdec_pkg::OP_LUI;
				d.imm = w & rvdec_pkg::UPPER_MASK;
			end
			rvdec_pkg::OPC_AUIPC: begin
				d.fmt = rvdec_pkg::FMT_U;
				d.op = rvdec_pkg::OP_AUIPC;
				d.imm = w & rvdec_pkg::UPPER_MASK;
			end
			rvdec_pkg::OPC_JAL: begin
				d.fmt = rvdec_pkg::FMT_J;
				d.op = rvdec_pkg::OP_JAL;
				d.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
			end
			default: ;
		endcase
		if (d.op == rvdec_pkg::OP_UNKNOWN) begin
			d.fmt = rvdec_pkg::FMT_UNK;
			d.imm = '0;
		end
		if (d.fmt == rvdec_pkg::FMT_R)
			d.imm = '0;
		return d;
	endfunction

	function automatic logic [31:0] build_word(input logic [6:0] f7, input logic [2:0] f3,
			input logic [6:0] opc);
		logic [31:0] w;
		w = $urandom;
		w[31:25] = f7;
		w[14:12] = f3;
		w[6:0] = opc;
		return w;
	endfunction

	function automatic logic [31:0] random_word();
		logic [31:0] w;
		w = $urandom;
		if ($urandom_range(99) < 85) begin
			case ($urandom_range(8))
				0: w[6:0] = rvdec_pkg::OPC_REG;
				1: w[6:0] = rvdec_pkg::OPC_IMM;
				2: w[6:0] = rvdec_pkg::OPC_LOAD;
				3: w[6:0] = rvdec_pkg::OPC_JALR;
				4: w[6:0] = rvdec_pkg::OPC_STORE;
				5: w[6:0] = rvdec_pkg::OPC_BRANCH;
				6: w[6:0] = rvdec_pkg::OPC_LUI;
				7: w[6:0] = rvdec_pkg::OPC_AUIPC;
				default: w[6:0] = rvdec_pkg::OPC_JAL;
			endcase
			case ($urandom_range(3))
				0: w[31:25] = rvdec_pkg::F7_BASE;
				1: w[31:25] = rvdec_pkg::F7_MULDIV;
				2: w[31:25] = rvdec_pkg::F7_ALT;
				default: ;
			endcase
		end
		return w;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] wv, input logic [31:0] gv);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: mismatch on %s: expected %h, got %h", $time, what, wv, gv);
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (expected_decodes.size() == 0) begin
				note_mismatch("unrequested result, opcode", '0, 32'(major_opcode));
			end else begin
				want = expected_decodes.pop_front();
				results_checked++;
				if (major_opcode !== want.opc)
					note_mismatch("major_opcode", 32'(want.opc), 32'(major_opcode));
				if (dest_reg !== want.rd)
					note_mismatch("dest_reg", 32'(want.rd), 32'(dest_reg));
				if (func3_field !== want.f3)
					note_mismatch("func3_field", 32'(want.f3), 32'(func3_field));
				if (src1_reg !== want.rs1)
					note_mismatch("src1_reg", 32'(want.rs1), 32'(src1_reg));
				if (src2_reg !== want.rs2)
					note_mismatch("src2_reg", 32'(want.rs2), 32'(src2_reg));
				if (func7_field !== want.f7)
					note_mismatch("func7_field", 32'(want.f7), 32'(func7_field));
				if (format_class !== want.fmt)
					note_mismatch("format_class", 32'(want.fmt), 32'(format_class));
				if (operation !== want.op)
					note_mismatch("operation", 32'(want.op), 32'(operation));
				if (immediate !== want.imm)
					note_mismatch("immediate", want.imm, immediate);
			end
		end
	end

	task automatic send_request(input logic [31:0] w);
		decoded_t d;
		if (idle_enabled && $urandom_range(99) < 7) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		instr_word <= w;
		do @(posedge clk); while (busy !== 1'b0);
		d = predict_decode(w);
		expected_decodes.push_back(d);
		op_hits[d.op]++;
		requests_sent++;
	endtask

	task automatic drain_requests();
		int waited;
		waited = 0;
		start <= 1'b0;
		while (expected_decodes.size() != 0 && waited < 200) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic test_field_extremes();
		send_request(32'h0000_0000);
		send_request(32'hFFFF_FFFF);
		send_request({12'h800, 13'h0, rvdec_pkg::OPC_IMM});
		send_request({12'h7FF, 13'h1FFF, rvdec_pkg::OPC_IMM});
		send_request({25'h1FF_FFFF, rvdec_pkg::OPC_LUI});
		send_request({25'h0, rvdec_pkg::OPC_AUIPC});
		send_request({25'h1FF_FFFF, rvdec_pkg::OPC_JAL});
		send_request({25'h0, rvdec_pkg::OPC_JAL});
		send_request({25'h1FF_FFFF, rvdec_pkg::OPC_BRANCH});
		send_request({7'h7F, 10'h3FF, 3'd2, 5'h1F, rvdec_pkg::OPC_STORE});
		send_request({7'h00, 10'h0, 3'd0, 5'h00, rvdec_pkg::OPC_STORE});
	endtask

	task automatic test_special_cases();
		send_request(build_word(rvdec_pkg::F7_ALT, rvdec_pkg::F3_SLL, rvdec_pkg::OPC_REG));
		send_request(build_word(7'h02, 3'd0, rvdec_pkg::OPC_REG));
		send_request(build_word(7'h7F, rvdec_pkg::F3_SLL, rvdec_pkg::OPC_IMM));
		send_request(build_word(7'h21, rvdec_pkg::F3_SRL, rvdec_pkg::OPC_IMM));
		send_request(build_word(rvdec_pkg::F7_ALT, rvdec_pkg::F3_SRL, rvdec_pkg::OPC_IMM));
		send_request(build_word(7'h60, rvdec_pkg::F3_SRL, rvdec_pkg::OPC_IMM));
		send_request(build_word(7'h7F, 3'd7, rvdec_pkg::OPC_JALR));
		send_request(build_word(7'h55, 3'd3, rvdec_pkg::OPC_LOAD));
		send_request(build_word(7'h2A, 3'd6, rvdec_pkg::OPC_LOAD));
		send_request(build_word(7'h13, 3'd5, rvdec_pkg::OPC_STORE));
		send_request(build_word(7'h40, 3'd2, rvdec_pkg::OPC_BRANCH));
		send_request(build_word(7'h3C, 3'd3, rvdec_pkg::OPC_BRANCH));
		send_request({20'hABCDE, 5'h15, rvdec_pkg::OPC_AUIPC});
		send_request(build_word(7'h11, 3'd4, 7'h7F));
		send_request(build_word(7'h00, 3'd0, 7'h0B));
	endtask

	task automatic test_every_operation();
		for (int f3 = 0; f3 < 8; f3++) begin
			send_request(build_word(rvdec_pkg::F7_BASE, f3[2:0], rvdec_pkg::OPC_REG));
			send_request(build_word(rvdec_pkg::F7_MULDIV, f3[2:0], rvdec_pkg::OPC_REG));
			send_request(build_word(rvdec_pkg::F7_ALT, f3[2:0], rvdec_pkg::OPC_REG));
			send_request(build_word(7'($urandom), f3[2:0], rvdec_pkg::OPC_IMM));
			send_request(build_word(7'($urandom), f3[2:0], rvdec_pkg::OPC_LOAD));
			send_request(build_word(7'($urandom), f3[2:0], rvdec_pkg::OPC_STORE));
			send_request(build_word(7'($urandom), f3[2:0], rvdec_pkg::OPC_BRANCH));
		end
		send_request(build_word(rvdec_pkg::F7_ALT, rvdec_pkg::F3_SRL, rvdec_pkg::OPC_IMM));
		send_request(build_word(7'($urandom), 3'($urandom), rvdec_pkg::OPC_JALR));
		send_request(build_word(7'($urandom), 3'($urandom), rvdec_pkg::OPC_LUI));
		send_request(build_word(7'($urandom), 3'($urandom), rvdec_pkg::OPC_AUIPC));
		send_request(build_word(7'($urandom), 3'($urandom), rvdec_pkg::OPC_JAL));
	endtask

	task automatic test_random_mix(input int count);
		repeat (count) send_request(random_word());
	endtask

	initial begin
		int ops_seen;
		foreach (op_hits[i]) op_hits[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_special_cases();
		test_every_operation();
		drain_requests();
		test_random_mix(450);
		idle_enabled = 1'b0;
		test_random_mix(350);
		idle_enabled = 1'b1;
		test_random_mix(350);
		drain_requests();
		ops_seen = 0;
		for (int i = 1; i <= 45; i++)
			if (op_hits[i] != 0) ops_seen++;
		$display("Decoded %0d instruction words, checked %0d results, %0d mismatches.",
			requests_sent, results_checked, mismatches);
		$display("Covered %0d of 45 mnemonics and %0d unknown encodings.",
			ops_seen, op_hits[rvdec_pkg::OP_UNKNOWN]);
		if (mismatches == 0 && expected_decodes.size() == 0) begin
			$display("** rv32im_instruction_decoder: PASSED **");
		end else begin
			if (expected_decodes.size() != 0)
				$display("%0d results never arrived", expected_decodes.size());
			$display("** rv32im_instruction_decoder: FAILED **");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/rvdec_pkg.sv
sv/rv32im_instruction_decoder.sv
sim/tb_rv32im_instruction_decoder.sv
